// ===== sv/eart_pkg.sv =====
// ----------------------------------------------------------------------------
// eart_pkg
// Shared constants for the Euler-angle rotation basis pipeline: Q.30 angle
// constants, CORDIC arctangent table and the plane/axis map of each rotation.
// ----------------------------------------------------------------------------
package eart_pkg;

  // Fraction bits of the internal fixed-point format
  localparam int FRAC = 30;
  // CORDIC iteration count
  localparam int STEPS = 20;
  // Angle accumulator width (full input range scaled to Q.30 plus headroom)
  localparam int Z_W = 36;
  // Width of sine, cosine and basis entries in Q.30
  localparam int E_W = 34;
  // Width of one full product
  localparam int P_W = 2 * E_W;

  localparam logic signed [Z_W-1:0] PI_Z      = Z_W'(64'sh0C90FDAA2);
  localparam logic signed [Z_W-1:0] HALF_PI_Z = Z_W'(64'sh06487ED51);
  localparam logic signed [E_W-1:0] GAIN_E    = E_W'(64'sh026DD3B6A);
  localparam logic signed [E_W-1:0] ONE_E     = E_W'(64'sh040000000);

  // Truncated arctangent table, Q.30
  localparam logic [31:0] ATAN_Q [STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF
  };

  // Rotation r: angle lane used, kept row, the two mixed rows, sine negation.
  // Angle lanes: 0 yaw, 1 pitch, 2 roll.
  localparam int ROT_ANG [3] = '{1, 0, 2};
  localparam int ROT_AX  [3] = '{1, 0, 2};
  localparam int ROT_F   [3] = '{0, 1, 0};
  localparam int ROT_G   [3] = '{2, 2, 1};
  localparam bit ROT_NEG [3] = '{1'b1, 1'b0, 1'b0};

  // Round a Q.60 product to Q.30 (add half, floor shift)
  function automatic logic signed [E_W-1:0] rnd_q(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] t;
    t = p + (P_W'(1) <<< (FRAC - 1));
    return t[FRAC+E_W-1:FRAC];
  endfunction

endpackage

// ===== sv/euler_angles_to_rotation_basis.sv =====
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_basis
// Turns three angles into a 3x3 rotation basis: pitch, then yaw, then roll
// applied as planar row rotations to the identity.
// ----------------------------------------------------------------------------
// A transaction enters on any cycle with start_i high; busy_o stays low, so a
// new transaction is taken every cycle. Each result is shown for one cycle
// with done_o high, in entry order. The pipeline holds the 20-stage
// unrolled CORDIC (one step per stage, all three angles side by side), one
// range-reduction stage, a sign-fix stage, two stages per row rotation
// (multiply, then round and add) and an output rounding/saturation register.
// The receiver cannot stall, so results must be taken as they appear.
module euler_angles_to_rotation_basis #(
  parameter int ANGLE_BITS = 16,
  parameter int OUT_BITS   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [ANGLE_BITS-1:0] yaw_angle_i,
  input  logic signed [ANGLE_BITS-1:0] pitch_angle_i,
  input  logic signed [ANGLE_BITS-1:0] roll_angle_i,
  output logic                         done_o,
  output logic signed [OUT_BITS-1:0]   r0c0_o,
  output logic signed [OUT_BITS-1:0]   r0c1_o,
  output logic signed [OUT_BITS-1:0]   r0c2_o,
  output logic signed [OUT_BITS-1:0]   r1c0_o,
  output logic signed [OUT_BITS-1:0]   r1c1_o,
  output logic signed [OUT_BITS-1:0]   r1c2_o,
  output logic signed [OUT_BITS-1:0]   r2c0_o,
  output logic signed [OUT_BITS-1:0]   r2c1_o,
  output logic signed [OUT_BITS-1:0]   r2c2_o
);
  import eart_pkg::*;

  localparam int LAT   = STEPS + 9;
  localparam int SH    = 32 - OUT_BITS;
  localparam int ASH   = 33 - ANGLE_BITS;
  localparam logic signed [E_W:0] HALF_O = (SH == 0) ? '0 : ((E_W+1)'(1) <<< (SH - 1));
  localparam logic signed [E_W:0] LIM_O  = (E_W+1)'(1) <<< (OUT_BITS - 2);

  logic [LAT-1:0] vld_q;

  logic signed [Z_W-1:0] z_q [STEPS+1][3];
  logic signed [E_W-1:0] x_q [STEPS+1][3];
  logic signed [E_W-1:0] y_q [STEPS+1][3];
  logic                  flip_q [STEPS+1][3];

  logic signed [E_W-1:0] sn_q [5][3];
  logic signed [E_W-1:0] cs_q [5][3];

  logic signed [P_W-1:0] pa_q [3][3];  // f * c
  logic signed [P_W-1:0] pb_q [3][3];  // s * g
  logic signed [P_W-1:0] pc_q [3][3];  // -s * f
  logic signed [P_W-1:0] pd_q [3][3];  // g * c
  logic signed [E_W-1:0] kr_q [3][3];  // kept row
  logic signed [E_W-1:0] mat_q [3][3][3];
  logic signed [E_W-1:0] mat_src [3][3][3];

  logic signed [OUT_BITS-1:0] out_q [3][3];

  logic signed [Z_W-1:0]      z_in [3];
  logic signed [Z_W-1:0]      z_red [3];
  logic                       flip_in [3];
  logic signed [ANGLE_BITS-1:0] ang [3];

  assign busy_o = 1'b0;
  assign done_o = vld_q[LAT-1];

  // Track valid transactions through the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start_i};
    end
  end

  // Scale angles to Q.30 and fold into +-pi/2
  always_comb begin
    ang[0] = yaw_angle_i;
    ang[1] = pitch_angle_i;
    ang[2] = roll_angle_i;
    for (int a = 0; a < 3; a++) begin
      z_in[a] = Z_W'($signed(ang[a])) <<< ASH;
      if (z_in[a] > HALF_PI_Z) begin
        z_red[a]   = z_in[a] - PI_Z;
        flip_in[a] = 1'b1;
      end else if (z_in[a] < -HALF_PI_Z) begin
        z_red[a]   = z_in[a] + PI_Z;
        flip_in[a] = 1'b1;
      end else begin
        z_red[a]   = z_in[a];
        flip_in[a] = 1'b0;
      end
    end
  end

  // CORDIC pipeline: one micro-rotation per stage
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      z_q[0][a]    <= z_red[a];
      x_q[0][a]    <= GAIN_E;
      y_q[0][a]    <= '0;
      flip_q[0][a] <= flip_in[a];
    end
    for (int k = 0; k < STEPS; k++) begin
      for (int a = 0; a < 3; a++) begin
        flip_q[k+1][a] <= flip_q[k][a];
        if (z_q[k][a] >= 0) begin
          x_q[k+1][a] <= x_q[k][a] - (y_q[k][a] >>> k);
          y_q[k+1][a] <= y_q[k][a] + (x_q[k][a] >>> k);
          z_q[k+1][a] <= z_q[k][a] - Z_W'(ATAN_Q[k]);
        end else begin
          x_q[k+1][a] <= x_q[k][a] + (y_q[k][a] >>> k);
          y_q[k+1][a] <= y_q[k][a] - (x_q[k][a] >>> k);
          z_q[k+1][a] <= z_q[k][a] + Z_W'(ATAN_Q[k]);
        end
      end
    end
  end

  // Undo range folding, then carry sine and cosine alongside the matrix
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      sn_q[0][a] <= flip_q[STEPS][a] ? -y_q[STEPS][a] : y_q[STEPS][a];
      cs_q[0][a] <= flip_q[STEPS][a] ? -x_q[STEPS][a] : x_q[STEPS][a];
      for (int j = 1; j < 5; j++) begin
        sn_q[j][a] <= sn_q[j-1][a];
        cs_q[j][a] <= cs_q[j-1][a];
      end
    end
  end

  // Select the matrix entering each rotation
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int l = 0; l < 3; l++) begin
        mat_src[0][i][l] = (i == l) ? ONE_E : '0;
        mat_src[1][i][l] = mat_q[0][i][l];
        mat_src[2][i][l] = mat_q[1][i][l];
      end
    end
  end

  // Row rotations: multiply stage, then round-and-add stage
  always_ff @(posedge clk_i) begin
    logic signed [E_W-1:0] s, ns, c;
    for (int r = 0; r < 3; r++) begin
      c  = cs_q[2*r][ROT_ANG[r]];
      s  = ROT_NEG[r] ? -sn_q[2*r][ROT_ANG[r]] : sn_q[2*r][ROT_ANG[r]];
      ns = -s;
      for (int l = 0; l < 3; l++) begin
        pa_q[r][l] <= P_W'(mat_src[r][ROT_F[r]][l]) * P_W'(c);
        pb_q[r][l] <= P_W'(s) * P_W'(mat_src[r][ROT_G[r]][l]);
        pc_q[r][l] <= P_W'(ns) * P_W'(mat_src[r][ROT_F[r]][l]);
        pd_q[r][l] <= P_W'(mat_src[r][ROT_G[r]][l]) * P_W'(c);
        kr_q[r][l] <= mat_src[r][ROT_AX[r]][l];
        mat_q[r][ROT_F[r]][l]  <= rnd_q(pa_q[r][l]) + rnd_q(pb_q[r][l]);
        mat_q[r][ROT_G[r]][l]  <= rnd_q(pc_q[r][l]) + rnd_q(pd_q[r][l]);
        mat_q[r][ROT_AX[r]][l] <= kr_q[r][l];
      end
    end
  end

  // Round to output format and saturate at +-1.0
  always_ff @(posedge clk_i) begin
    logic signed [E_W:0] v;
    for (int i = 0; i < 3; i++) begin
      for (int l = 0; l < 3; l++) begin
        v = ((E_W+1)'(mat_q[2][i][l]) + HALF_O) >>> SH;
        if (v > LIM_O) begin
          out_q[i][l] <= OUT_BITS'(LIM_O);
        end else if (v < -LIM_O) begin
          out_q[i][l] <= OUT_BITS'(-LIM_O);
        end else begin
          out_q[i][l] <= v[OUT_BITS-1:0];
        end
      end
    end
  end

  assign r0c0_o = out_q[0][0];
  assign r0c1_o = out_q[0][1];
  assign r0c2_o = out_q[0][2];
  assign r1c0_o = out_q[1][0];
  assign r1c1_o = out_q[1][1];
  assign r1c2_o = out_q[1][2];
  assign r2c0_o = out_q[2][0];
  assign r2c1_o = out_q[2][1];
  assign r2c2_o = out_q[2][2];

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for euler_angles_to_rotation_basis: angle triples are
// sent directed and in random bursts, a bit-exact CORDIC predictor computes
// each expected basis, and a monitor compares every strobed result in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int AW = 16;
  localparam int OW = 16;
  localparam int LATENCY = 29;

  typedef struct packed {
    logic signed [OW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  } basis_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic signed [AW-1:0] yaw_angle_i = '0;
  logic signed [AW-1:0] pitch_angle_i = '0;
  logic signed [AW-1:0] roll_angle_i = '0;
  logic busy_o, done_o;
  logic signed [OW-1:0] r0c0_o, r0c1_o, r0c2_o, r1c0_o, r1c1_o, r1c2_o;
  logic signed [OW-1:0] r2c0_o, r2c1_o, r2c2_o;

  basis_t expected_bases[$];
  int     fail_count = 0;

  euler_angles_to_rotation_basis #(.ANGLE_BITS(AW), .OUT_BITS(OW)) dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .yaw_angle_i, .pitch_angle_i, .roll_angle_i, .done_o,
    .r0c0_o, .r0c1_o, .r0c2_o, .r1c0_o, .r1c1_o, .r1c2_o,
    .r2c0_o, .r2c1_o, .r2c2_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Floor shift that matches the hardware arithmetic shift
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_q30(longint p);
    return floor_shr(p + (64'sd1 <<< 29), 30);
  endfunction

  // Sine and cosine in Q.30 by fixed-length CORDIC with one reduction by pi
  task automatic sin_cos(input longint z_in, output longint sn, output longint cs);
    longint x, y, z, dx, dy;
    bit flip;
    longint atan_tab [20] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF};
    z = z_in; x = 64'h26DD3B6A; y = 0; flip = 0;
    if (z > 64'sh6487ED51) begin
      z -= 64'hC90FDAA2; flip = 1;
    end else if (z < -64'sh6487ED51) begin
      z += 64'hC90FDAA2; flip = 1;
    end
    for (int i = 0; i < 20; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  // Mix rows f and g of the basis by one planar rotation
  task automatic mix_rows(inout longint m[3][3], input int f, input int g,
                          input bit neg, input logic signed [AW-1:0] ang);
    longint sn, cs, s, a, b;
    sin_cos(longint'(ang) <<< (33 - AW), sn, cs);
    s = neg ? -sn : sn;
    for (int c = 0; c < 3; c++) begin
      a = m[f][c]; b = m[g][c];
      m[f][c] = round_q30(a * cs) + round_q30(s * b);
      m[g][c] = round_q30(-s * a) + round_q30(b * cs);
    end
  endtask

  function automatic logic signed [OW-1:0] to_q14(longint v);
    longint r, lim;
    lim = 64'sd1 <<< (OW - 2);
    r = floor_shr(v + (64'sd1 <<< (31 - OW)), 32 - OW);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return OW'(r);
  endfunction

  // Predict the basis for one angle triple: pitch, then yaw, then roll
  task automatic predict_basis(input logic signed [AW-1:0] yaw,
                               input logic signed [AW-1:0] pitch,
                               input logic signed [AW-1:0] roll);
    longint m[3][3];
    basis_t b;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        m[r][c] = (r == c) ? (64'sd1 <<< 30) : 0;
    mix_rows(m, 0, 2, 1'b1, pitch);
    mix_rows(m, 1, 2, 1'b0, yaw);
    mix_rows(m, 0, 1, 1'b0, roll);
    b.e00 = to_q14(m[0][0]); b.e01 = to_q14(m[0][1]); b.e02 = to_q14(m[0][2]);
    b.e10 = to_q14(m[1][0]); b.e11 = to_q14(m[1][1]); b.e12 = to_q14(m[1][2]);
    b.e20 = to_q14(m[2][0]); b.e21 = to_q14(m[2][1]); b.e22 = to_q14(m[2][2]);
    expected_bases.push_back(b);
  endtask

  // Send one transaction and hold until it is accepted
  task automatic send_angles(input logic signed [AW-1:0] yaw,
                             input logic signed [AW-1:0] pitch,
                             input logic signed [AW-1:0] roll);
    start_i <= 1'b1;
    yaw_angle_i <= yaw;
    pitch_angle_i <= pitch;
    roll_angle_i <= roll;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_basis(yaw, pitch, roll);
  endtask

  task automatic idle_cycles(input int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Drop start and wait until every result has come
  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (expected_bases.size() != 0);
  endtask

  function automatic logic signed [AW-1:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return AW'($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000);
      1: return AW'(int'($urandom_range(0, 40)) - 20);
      2: return AW'(($urandom_range(0, 1) ? 12868 : -12868)
                    + int'($urandom_range(0, 8)) - 4);
      default: return AW'($urandom);
    endcase
  endfunction

  // Extremes, zero, quarter and half turns and the reduction boundaries
  task automatic test_directed();
    logic signed [AW-1:0] corners [8] = '{16'sh0000, 16'sh7FFF, 16'sh8000,
      16'sd12868, -16'sd12868, 16'sd12869, -16'sd12869, 16'sd25736};
    send_angles('0, '0, '0);
    for (int i = 1; i < 8; i++) send_angles(corners[i], '0, '0);
    for (int i = 1; i < 8; i++) send_angles('0, corners[i], '0);
    for (int i = 1; i < 8; i++) send_angles('0, '0, corners[i]);
    send_angles(16'sh7FFF, 16'sh8000, 16'sh5555);
    send_angles(16'shAAAA, 16'sh7FFF, 16'sh8000);
    idle_cycles(1);
  endtask

  // Random bursts with random gaps, and one full pause until drained midway
  task automatic test_random_bursts(input int total);
    int sent, burst;
    sent = 0;
    while (sent < total) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < total; i++) begin
        send_angles(rand_angle(), rand_angle(), rand_angle());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 35));
      if (sent > total / 2 && sent - burst <= total / 2) drain_results();
    end
  endtask

  // Compare every strobed result against the oldest prediction
  always @(posedge clk_i) begin
    basis_t got, want;
    if (rst_ni && done_o) begin
      got = {r0c0_o, r0c1_o, r0c2_o, r1c0_o, r1c1_o, r1c2_o, r2c0_o, r2c1_o, r2c2_o};
      if (expected_bases.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fail_count++;
      end else begin
        want = expected_bases.pop_front();
        for (int k = 0; k < 9; k++)
          if (got[16*k +: 16] !== want[16*k +: 16]) begin
            $display("%0t: entry %0d expected %0d actual %0d", $time, 8 - k,
                     $signed(want[16*k +: 16]), $signed(got[16*k +: 16]));
            fail_count++;
          end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_bursts(1700);
    drain_results();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (fail_count == 0 && expected_bases.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Hold a hard stop well beyond the slowest legal run
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule
